// ===== rtl/pah_pkg.sv =====
`timescale 1ns / 1ps
// shared types, codes and constants of the peer ack stability horizon block
package pah_pkg;

  localparam int MAX_PEERS_DEF = 16;

  localparam int ID_W    = 32;
  localparam int STAMP_W = 64;
  localparam int NOW_W   = 63;
  localparam int LEASE_W = 32;
  localparam int CMD_W   = 3;

  localparam logic [LEASE_W-1:0] LEASE_RST = 32'd30000;
  localparam logic [LEASE_W-1:0] CNT_MAX   = 32'hFFFF_FFFF;

  // command codes
  localparam logic [CMD_W-1:0] CMD_ACK     = 3'd0;
  localparam logic [CMD_W-1:0] CMD_HEART   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_REG     = 3'd2;
  localparam logic [CMD_W-1:0] CMD_UNREG   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_EJECT   = 3'd4;
  localparam logic [CMD_W-1:0] CMD_HORIZON = 3'd5;
  localparam logic [CMD_W-1:0] CMD_RESET   = 3'd6;
  // code with no meaning, answered as refused
  localparam logic [CMD_W-1:0] CMD_UNUSED  = 3'd7;

  // configuration register indexes
  localparam logic CFG_OWN_ID = 1'b0;
  localparam logic CFG_LEASE  = 1'b1;

  // command token walking down the cell row
  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [ID_W-1:0]    id;
    logic [STAMP_W-1:0] stamp;
    logic [NOW_W-1:0]   now;
    logic [STAMP_W-1:0] local_stamp;
    logic               refused;
    logic               found;
    logic               free_seen;
    logic               live;
    logic [STAMP_W-1:0] lo;
  } tok_t;

  // new entry written into a free cell
  typedef struct packed {
    logic [ID_W-1:0]    peer;
    logic [STAMP_W-1:0] acked;
    logic [NOW_W-1:0]   heard;
  } ins_t;

endpackage

// ===== rtl/pah_cell.sv =====
`timescale 1ns / 1ps
// one table entry: applies the passing command to its entry and hands the word on
module pah_cell #(
  parameter int MAX_PEERS = pah_pkg::MAX_PEERS_DEF,
  parameter int IDX       = 0
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [pah_pkg::LEASE_W-1:0]       lease,
  input  logic                              tok_vld,
  input  pah_pkg::tok_t                     tok,
  input  logic [$clog2(MAX_PEERS+1)-1:0]    trk,
  input  logic [$clog2(MAX_PEERS+1)-1:0]    qrm,
  input  logic [$clog2(MAX_PEERS+1)-1:0]    ejd,
  input  logic [$clog2(MAX_PEERS+1)-1:0]    ejn,
  input  logic [(MAX_PEERS > 1 ? $clog2(MAX_PEERS) : 1)-1:0] free_idx,
  input  logic                              ins_en,
  input  logic [(MAX_PEERS > 1 ? $clog2(MAX_PEERS) : 1)-1:0] ins_idx,
  input  pah_pkg::ins_t                     ins,
  output logic                              tok_vld_r,
  output pah_pkg::tok_t                     tok_r,
  output logic [$clog2(MAX_PEERS+1)-1:0]    trk_r,
  output logic [$clog2(MAX_PEERS+1)-1:0]    qrm_r,
  output logic [$clog2(MAX_PEERS+1)-1:0]    ejd_r,
  output logic [$clog2(MAX_PEERS+1)-1:0]    ejn_r,
  output logic [(MAX_PEERS > 1 ? $clog2(MAX_PEERS) : 1)-1:0] free_idx_r
);

  localparam int CW = $clog2(MAX_PEERS+1);
  localparam int IW = (MAX_PEERS > 1) ? $clog2(MAX_PEERS) : 1;
  localparam logic [IW-1:0] MY_IDX = IW'(IDX);

  logic                        v_r, v_nxt;
  logic [pah_pkg::ID_W-1:0]    peer_r;
  logic [pah_pkg::STAMP_W-1:0] acked_r, acked_nxt;
  logic [pah_pkg::NOW_W-1:0]   heard_r, heard_nxt;
  logic                        out_r, out_nxt;
  logic                        match, touch_ok, expire, ej_inc;
  logic [pah_pkg::NOW_W-1:0]   age;
  pah_pkg::tok_t               tok_nxt;
  logic [IW-1:0]               free_nxt;

  assign match    = v_r && (peer_r == tok.id);
  assign touch_ok = match && !tok.refused;
  assign age      = tok.now - heard_r;
  assign expire   = (heard_r != '0) && (tok.now > heard_r) &&
                    (age > {{(pah_pkg::NOW_W-pah_pkg::LEASE_W){1'b0}}, lease}) && !out_r;

  // entry update for the passing command
  always_comb begin
    v_nxt     = v_r;
    acked_nxt = acked_r;
    heard_nxt = heard_r;
    out_nxt   = out_r;
    ej_inc    = 1'b0;
    tok_nxt   = tok;
    free_nxt  = free_idx;
    if (!v_r && !tok.free_seen) begin
      tok_nxt.free_seen = 1'b1;
      free_nxt          = MY_IDX;
    end
    unique case (tok.cmd)
      pah_pkg::CMD_ACK, pah_pkg::CMD_HEART, pah_pkg::CMD_REG: begin
        if (touch_ok) begin
          tok_nxt.found = 1'b1;
          heard_nxt     = tok.now;
          out_nxt       = 1'b0;
          if (tok.cmd == pah_pkg::CMD_REG) begin
            acked_nxt = tok.stamp;
          end else if (tok.cmd == pah_pkg::CMD_ACK && tok.stamp > acked_r) begin
            acked_nxt = tok.stamp;
          end
        end
      end
      pah_pkg::CMD_UNREG: begin
        if (match) begin
          tok_nxt.found = 1'b1;
          v_nxt         = 1'b0;
        end
      end
      pah_pkg::CMD_EJECT: begin
        if (match) begin
          tok_nxt.found = 1'b1;
          if (!out_r) begin
            out_nxt = 1'b1;
            ej_inc  = 1'b1;
          end
        end
      end
      pah_pkg::CMD_HORIZON: begin
        if (v_r) begin
          if (expire) begin
            out_nxt = 1'b1;
            ej_inc  = 1'b1;
          end
          if (!(out_r || expire)) begin
            tok_nxt.live = 1'b1;
            if (acked_r < tok.lo) tok_nxt.lo = acked_r;
          end
        end
      end
      pah_pkg::CMD_RESET: begin
        v_nxt = 1'b0;
      end
      default: begin
      end
    endcase
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (ins_en && ins_idx == MY_IDX) begin
      v_r <= 1'b1;
    end else if (tok_vld) begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ins_en && ins_idx == MY_IDX) begin
      peer_r  <= ins.peer;
      acked_r <= ins.acked;
      heard_r <= ins.heard;
      out_r   <= 1'b0;
    end else if (tok_vld) begin
      acked_r <= acked_nxt;
      heard_r <= heard_nxt;
      out_r   <= out_nxt;
    end
  end

  // hand the word to the next cell
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_vld_r <= 1'b0;
    end else begin
      tok_vld_r <= tok_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (tok_vld) begin
      tok_r      <= tok_nxt;
      free_idx_r <= free_nxt;
      trk_r      <= trk + CW'(v_nxt);
      qrm_r      <= qrm + CW'(v_nxt && !out_nxt);
      ejd_r      <= ejd + CW'(v_nxt && out_nxt);
      ejn_r      <= ejn + CW'(ej_inc);
    end
  end

endmodule

// ===== rtl/peer_ack_stability_horizon_core.sv =====
`timescale 1ns / 1ps
// peer ack table with stability horizon, built as a row of entry cells
// the word is registered in each cell in turn, captured after the last cell, then registered at the outputs
// only one word walks the cell row at a time; no new word is taken while one is in flight
// the next word is taken as soon as the result is registered, even before it is read
// reset (rst_n low, synchronous) empties the table, clears the ejection count,
// sets own_node_id to 0 and lease_ms to 30000
module peer_ack_stability_horizon_core #(
  parameter int MAX_PEERS = pah_pkg::MAX_PEERS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic                               cfg_index,
  input  logic [31:0]                        cfg_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [pah_pkg::CMD_W-1:0]          in_cmd,
  input  logic [pah_pkg::ID_W-1:0]           in_peer_num,
  input  logic [pah_pkg::STAMP_W-1:0]        in_stamp,
  input  logic [pah_pkg::NOW_W-1:0]          in_now_ms,
  input  logic [pah_pkg::STAMP_W-1:0]        in_local_stamp,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               out_accepted,
  output logic [pah_pkg::STAMP_W-1:0]        out_horizon,
  output logic [$clog2(MAX_PEERS+1)-1:0]     out_entry_count,
  output logic [$clog2(MAX_PEERS+1)-1:0]     out_quorum_count,
  output logic [$clog2(MAX_PEERS+1)-1:0]     out_ejected_peers,
  output logic [31:0]                        out_ejection_total
);

  localparam int CW = $clog2(MAX_PEERS+1);
  localparam int IW = (MAX_PEERS > 1) ? $clog2(MAX_PEERS) : 1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]                  st_r, st_nxt;
  logic [31:0]                 own_r;
  logic [pah_pkg::LEASE_W-1:0] lease_r;
  logic [31:0]                 ejc_r, ejc_nxt;
  logic [32:0]                 ejc_sum;

  logic          c_vld [0:MAX_PEERS];
  pah_pkg::tok_t c_tok [0:MAX_PEERS];
  logic [CW-1:0] c_trk [0:MAX_PEERS];
  logic [CW-1:0] c_qrm [0:MAX_PEERS];
  logic [CW-1:0] c_ejd [0:MAX_PEERS];
  logic [CW-1:0] c_ejn [0:MAX_PEERS];
  logic [IW-1:0] c_free [0:MAX_PEERS];

  pah_pkg::tok_t fin_r;
  logic [CW-1:0] fin_trk_r, fin_qrm_r, fin_ejd_r, fin_ejn_r;
  logic [IW-1:0] fin_free_r;

  logic          take, finish, is_touch, ins_en, acc;
  pah_pkg::ins_t ins;
  logic [pah_pkg::STAMP_W-1:0] hz;

  assign cfg_ready = 1'b1;
  assign in_ready  = (st_r == ST_IDLE);
  assign take      = in_valid && in_ready;
  assign finish    = (st_r == ST_DONE) && (!out_valid || out_ready);

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_r   <= '0;
      lease_r <= pah_pkg::LEASE_RST;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == pah_pkg::CFG_OWN_ID) own_r <= cfg_data;
      else                                  lease_r <= cfg_data;
    end
  end

  // word entering the first cell
  always_comb begin
    c_vld[0]             = take;
    c_tok[0].cmd         = in_cmd;
    c_tok[0].id          = in_peer_num;
    c_tok[0].stamp       = in_stamp;
    c_tok[0].now         = in_now_ms;
    c_tok[0].local_stamp = in_local_stamp;
    c_tok[0].refused     = (in_peer_num == '0) || (in_peer_num == own_r);
    c_tok[0].found       = 1'b0;
    c_tok[0].free_seen   = 1'b0;
    c_tok[0].live        = 1'b0;
    c_tok[0].lo          = '1;
    c_trk[0]             = '0;
    c_qrm[0]             = '0;
    c_ejd[0]             = '0;
    c_ejn[0]             = '0;
    c_free[0]            = '0;
  end

  // row of entry cells
  for (genvar g = 0; g < MAX_PEERS; g++) begin : g_cell
    pah_cell #(.MAX_PEERS(MAX_PEERS), .IDX(g)) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .lease      (lease_r),
      .tok_vld    (c_vld[g]),
      .tok        (c_tok[g]),
      .trk        (c_trk[g]),
      .qrm        (c_qrm[g]),
      .ejd        (c_ejd[g]),
      .ejn        (c_ejn[g]),
      .free_idx   (c_free[g]),
      .ins_en     (ins_en),
      .ins_idx    (fin_free_r),
      .ins        (ins),
      .tok_vld_r  (c_vld[g+1]),
      .tok_r      (c_tok[g+1]),
      .trk_r      (c_trk[g+1]),
      .qrm_r      (c_qrm[g+1]),
      .ejd_r      (c_ejd[g+1]),
      .ejn_r      (c_ejn[g+1]),
      .free_idx_r (c_free[g+1])
    );
  end

  // capture the word leaving the last cell
  always_ff @(posedge clk) begin
    if (c_vld[MAX_PEERS]) begin
      fin_r      <= c_tok[MAX_PEERS];
      fin_trk_r  <= c_trk[MAX_PEERS];
      fin_qrm_r  <= c_qrm[MAX_PEERS];
      fin_ejd_r  <= c_ejd[MAX_PEERS];
      fin_ejn_r  <= c_ejn[MAX_PEERS];
      fin_free_r <= c_free[MAX_PEERS];
    end
  end

  // insert of a new peer into the lowest free cell
  assign is_touch = (fin_r.cmd == pah_pkg::CMD_ACK) || (fin_r.cmd == pah_pkg::CMD_HEART) ||
                    (fin_r.cmd == pah_pkg::CMD_REG);
  assign ins_en   = finish && is_touch && !fin_r.refused && !fin_r.found && fin_r.free_seen;
  assign ins.peer  = fin_r.id;
  assign ins.acked = (fin_r.cmd == pah_pkg::CMD_HEART) ? '0 : fin_r.stamp;
  assign ins.heard = fin_r.now;

  // result fields
  always_comb begin
    acc = 1'b0;
    hz  = '0;
    unique case (fin_r.cmd)
      pah_pkg::CMD_ACK, pah_pkg::CMD_HEART, pah_pkg::CMD_REG:
        acc = !fin_r.refused && (fin_r.found || fin_r.free_seen);
      pah_pkg::CMD_UNREG, pah_pkg::CMD_EJECT:
        acc = fin_r.found;
      pah_pkg::CMD_HORIZON: begin
        acc = 1'b1;
        if (!fin_r.live || fin_r.local_stamp < fin_r.lo) hz = fin_r.local_stamp;
        else                                             hz = fin_r.lo;
      end
      pah_pkg::CMD_RESET:
        acc = 1'b1;
      default: begin
      end
    endcase
  end

  // saturating ejection count
  assign ejc_sum = {1'b0, ejc_r} + 33'(fin_ejn_r);
  always_comb begin
    if (fin_r.cmd == pah_pkg::CMD_RESET) ejc_nxt = '0;
    else if (ejc_sum[32])                ejc_nxt = pah_pkg::CNT_MAX;
    else                                 ejc_nxt = ejc_sum[31:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ejc_r <= '0;
    end else if (finish) begin
      ejc_r <= ejc_nxt;
    end
  end

  // sequencer
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE: if (take) st_nxt = ST_RUN;
      ST_RUN:  if (c_vld[MAX_PEERS]) st_nxt = ST_DONE;
      ST_DONE: if (finish) st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      out_accepted       <= acc;
      out_horizon        <= hz;
      out_entry_count    <= fin_trk_r + CW'(ins_en);
      out_quorum_count   <= fin_qrm_r + CW'(ins_en);
      out_ejected_peers  <= fin_ejd_r;
      out_ejection_total <= ejc_nxt;
    end
  end

endmodule

// ===== rtl/pah_checker.sv =====
`timescale 1ns / 1ps
// port-level checks of the peer ack stability horizon block, bound to the top level
module pah_checker #(
  parameter int MAX_PEERS = pah_pkg::MAX_PEERS_DEF
) (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic                           out_accepted,
  input logic [pah_pkg::STAMP_W-1:0]    out_horizon,
  input logic [$clog2(MAX_PEERS+1)-1:0] out_entry_count,
  input logic [$clog2(MAX_PEERS+1)-1:0] out_quorum_count,
  input logic [$clog2(MAX_PEERS+1)-1:0] out_ejected_peers
);

  localparam int CW = $clog2(MAX_PEERS+1);

  // a waiting result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_horizon))
    else $error("result word dropped or changed while stalled");

  // one word at a time in the cell row
  a_one_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second word taken while one is in flight");

  // counts agree
  a_counts: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_entry_count == out_quorum_count + out_ejected_peers) &&
                  (out_entry_count <= CW'(MAX_PEERS)))
    else $error("entry counts inconsistent");

  // a nonzero horizon only on an accepted command
  a_hz: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_horizon != '0) |-> out_accepted)
    else $error("horizon value on refused command");

endmodule

bind peer_ack_stability_horizon_core pah_checker #(.MAX_PEERS(MAX_PEERS)) u_pah_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_ready          (in_ready),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_accepted      (out_accepted),
  .out_horizon       (out_horizon),
  .out_entry_count   (out_entry_count),
  .out_quorum_count  (out_quorum_count),
  .out_ejected_peers (out_ejected_peers)
);

// ===== tb/tb_peer_ack_stability_horizon_core.sv =====
`timescale 1ns / 1ps
// testbench for the peer ack table: directed table plus random traffic against a predictor
module tb_peer_ack_stability_horizon_core;

  localparam int NPEER = 16;
  localparam int CNT_W = $clog2(NPEER + 1);
  localparam int WATCHDOG = 20000;
  localparam int SETTLE = NPEER + 8;
  localparam int HOLD_CYCLES = 400;

  typedef logic [pah_pkg::CMD_W-1:0]   cmd_t;
  typedef logic [pah_pkg::ID_W-1:0]    id_t;
  typedef logic [pah_pkg::STAMP_W-1:0] stamp_t;
  typedef logic [pah_pkg::NOW_W-1:0]   now_t;

  typedef struct packed {
    cmd_t   cmd;
    id_t    peer;
    stamp_t stamp;
    now_t   now;
    stamp_t lstamp;
  } cmd_word_t;

  typedef struct packed {
    logic             accepted;
    stamp_t           horizon;
    logic [CNT_W-1:0] tracked;
    logic [CNT_W-1:0] quorum;
    logic [CNT_W-1:0] ejected;
    logic [31:0]      total;
  } reply_t;

  // directed row: command plus optional typed-in expectation
  typedef struct {
    cmd_word_t w;
    bit        fixed;
    reply_t    r;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0, cfg_index = 1'b0;
  logic [31:0] cfg_data = '0;
  logic cfg_ready;
  logic in_valid = 1'b0;
  logic in_ready;
  cmd_t in_cmd = '0;
  id_t in_peer_num = '0;
  stamp_t in_stamp = '0, in_local_stamp = '0;
  now_t in_now_ms = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_accepted;
  stamp_t out_horizon;
  logic [CNT_W-1:0] out_entry_count, out_quorum_count, out_ejected_peers;
  logic [31:0] out_ejection_total;

  peer_ack_stability_horizon_core dut (.*);

  initial begin
    forever #6 clk = ~clk;
  end

  // predictor copy of the peer table
  logic [31:0] own_id;
  logic [31:0] lease;
  logic        tv [NPEER];
  id_t         tpeer [NPEER];
  stamp_t      tacked [NPEER];
  now_t        theard [NPEER];
  logic        tout [NPEER];
  logic [31:0] ej_cnt;

  reply_t expected_replies [$];
  bit     typed_flag_q [$];
  reply_t typed_val_q [$];
  bit     typed_on = 1'b0;
  reply_t typed_r = '0;
  int errors = 0;
  int words_done = 0;
  int replies_seen = 0;
  int idle_cycles = 0;
  bit long_hold = 1'b0;
  bit hold_req = 1'b0;
  now_t clock_ms = '0;

  function automatic void table_clear();
    for (int i = 0; i < NPEER; i++) tv[i] = 1'b0;
    ej_cnt = '0;
  endfunction

  function automatic int lookup(id_t id);
    for (int i = 0; i < NPEER; i++)
      if (tv[i] && tpeer[i] == id) return i;
    return -1;
  endfunction

  function automatic void bump_ejections();
    if (ej_cnt != pah_pkg::CNT_MAX) ej_cnt++;
  endfunction

  // compute reply to one word and update the table
  function automatic reply_t apply_command(cmd_word_t w);
    reply_t r;
    int s;
    stamp_t lo;
    int live;
    r = '0;
    case (w.cmd)
      pah_pkg::CMD_ACK, pah_pkg::CMD_HEART, pah_pkg::CMD_REG: begin
        if (w.peer != '0 && w.peer != own_id) begin
          s = lookup(w.peer);
          if (s < 0) begin
            for (int i = 0; i < NPEER; i++)
              if (!tv[i] && s < 0) s = i;
            if (s >= 0) begin
              tv[s] = 1'b1;
              tpeer[s] = w.peer;
              tacked[s] = (w.cmd == pah_pkg::CMD_HEART) ? '0 : w.stamp;
            end
          end else if (w.cmd == pah_pkg::CMD_ACK) begin
            if (w.stamp > tacked[s]) tacked[s] = w.stamp;
          end else if (w.cmd == pah_pkg::CMD_REG) begin
            tacked[s] = w.stamp;
          end
          if (s >= 0) begin
            theard[s] = w.now;
            tout[s] = 1'b0;
            r.accepted = 1'b1;
          end
        end
      end
      pah_pkg::CMD_UNREG: begin
        s = lookup(w.peer);
        if (s >= 0) begin
          tv[s] = 1'b0;
          r.accepted = 1'b1;
        end
      end
      pah_pkg::CMD_EJECT: begin
        s = lookup(w.peer);
        if (s >= 0) begin
          if (!tout[s]) begin
            tout[s] = 1'b1;
            bump_ejections();
          end
          r.accepted = 1'b1;
        end
      end
      pah_pkg::CMD_HORIZON: begin
        lo = '1;
        live = 0;
        for (int i = 0; i < NPEER; i++) begin
          if (tv[i]) begin
            if (theard[i] != '0 && w.now > theard[i] &&
                (w.now - theard[i]) > {31'd0, lease} && !tout[i]) begin
              tout[i] = 1'b1;
              bump_ejections();
            end
            if (!tout[i]) begin
              if (tacked[i] < lo) lo = tacked[i];
              live++;
            end
          end
        end
        r.horizon = (live == 0) ? w.lstamp : ((w.lstamp < lo) ? w.lstamp : lo);
        r.accepted = 1'b1;
      end
      pah_pkg::CMD_RESET: begin
        table_clear();
        r.accepted = 1'b1;
      end
      default: ;
    endcase
    for (int i = 0; i < NPEER; i++)
      if (tv[i]) begin
        r.tracked++;
        if (tout[i]) r.ejected++;
        else r.quorum++;
      end
    r.total = ej_cnt;
    return r;
  endfunction

  // compare the result ports with one expectation
  function automatic void check_fields(reply_t e);
    if (out_accepted !== e.accepted) begin
      $error("accepted exp %0h got %0h", e.accepted, out_accepted); errors++;
    end
    if (out_horizon !== e.horizon) begin
      $error("horizon exp %0h got %0h", e.horizon, out_horizon); errors++;
    end
    if (out_entry_count !== e.tracked) begin
      $error("entry_count exp %0d got %0d", e.tracked, out_entry_count); errors++;
    end
    if (out_quorum_count !== e.quorum) begin
      $error("quorum_count exp %0d got %0d", e.quorum, out_quorum_count); errors++;
    end
    if (out_ejected_peers !== e.ejected) begin
      $error("ejected_peers exp %0d got %0d", e.ejected, out_ejected_peers); errors++;
    end
    if (out_ejection_total !== e.total) begin
      $error("ejection_total exp %0d got %0d", e.total, out_ejection_total);
      errors++;
    end
  endfunction

  // sender: bursts and gaps, word stays put until accepted
  task automatic send_word(cmd_word_t w);
    if (!long_hold && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= w.cmd;
    in_peer_num <= w.peer;
    in_stamp <= w.stamp;
    in_now_ms <= w.now;
    in_local_stamp <= w.lstamp;
    do @(posedge clk); while (!in_ready);
    words_done++;
    @(negedge clk);
  endtask

  task automatic write_reg(logic idx, logic [31:0] val);
    @(negedge clk);
    in_valid <= 1'b0;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == pah_pkg::CFG_OWN_ID) own_id = val;
    else lease = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_replies.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  // accepted word: predict at the accepting edge
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      expected_replies.push_back(apply_command({in_cmd, in_peer_num, in_stamp,
                                                in_now_ms, in_local_stamp}));
      typed_flag_q.push_back(typed_on);
      typed_val_q.push_back(typed_r);
    end
  end

  // result check against the oldest expectation
  always @(posedge clk) begin
    reply_t e;
    reply_t t;
    bit tf;
    if (rst_n && out_valid && out_ready) begin
      replies_seen++;
      if (expected_replies.size() == 0) begin
        $error("result word with nothing expected");
        errors++;
      end else begin
        e = expected_replies.pop_front();
        tf = typed_flag_q.pop_front();
        t = typed_val_q.pop_front();
        check_fields(e);
        // typed-in expectation of a directed row
        if (tf) check_fields(t);
      end
    end
  end

  // receiver stall pattern plus one long hold-off on request
  initial begin
    int ph;
    ph = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      ph++;
      if (hold_req) begin
        hold_req = 1'b0;
        long_hold = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        long_hold = 1'b0;
      end else if (ph % 200 < 60) out_ready <= 1'b1;
      else out_ready <= ($urandom_range(0, 2) != 0);
    end
  end

  // watchdog on cycles with no handshake
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic cmd_word_t mk(cmd_t c, id_t p, stamp_t s, now_t n, stamp_t l);
    cmd_word_t w;
    w = {c, p, s, n, l};
    return w;
  endfunction

  function automatic reply_t rp(logic a, stamp_t h, int t, int q, int e, int x);
    reply_t r;
    r = {a, h, CNT_W'(t), CNT_W'(q), CNT_W'(e), 32'(x)};
    return r;
  endfunction

  // random time step keeps now non-decreasing
  function automatic now_t tick();
    case ($urandom_range(0, 9))
      0: clock_ms = clock_ms;
      1: clock_ms = clock_ms + now_t'({$urandom, $urandom} % 64'd200000);
      default: clock_ms = clock_ms + now_t'($urandom_range(0, 600));
    endcase
    return clock_ms;
  endfunction

  function automatic stamp_t rnd64();
    case ($urandom_range(0, 5))
      0: return '1;
      1: return '0;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic cmd_word_t rand_word(int id_span);
    cmd_word_t w;
    int k;
    id_t id;
    k = $urandom_range(0, 99);
    id = id_t'($urandom_range(1, id_span));
    if ($urandom_range(0, 30) == 0) id = '0;
    else if ($urandom_range(0, 30) == 0) id = own_id;
    else if ($urandom_range(0, 40) == 0) id = $urandom;
    w = mk(pah_pkg::CMD_ACK, id, rnd64(), tick(), rnd64());
    if (k < 25) w.cmd = pah_pkg::CMD_ACK;
    else if (k < 45) w.cmd = pah_pkg::CMD_HEART;
    else if (k < 55) w.cmd = pah_pkg::CMD_REG;
    else if (k < 65) w.cmd = pah_pkg::CMD_UNREG;
    else if (k < 72) w.cmd = pah_pkg::CMD_EJECT;
    else if (k < 97) w.cmd = pah_pkg::CMD_HORIZON;
    else if (k < 98) w.cmd = pah_pkg::CMD_RESET;
    else w.cmd = pah_pkg::CMD_UNUSED;
    return w;
  endfunction

  row_t dir [$];

  initial begin
    own_id = 32'd0;
    lease = pah_pkg::LEASE_RST;
    table_clear();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed table
    dir.push_back('{mk(pah_pkg::CMD_HORIZON, '0, '0, '0, 64'd77), 1'b1,
                    rp(1'b1, 64'd77, 0, 0, 0, 0)});
    dir.push_back('{mk(pah_pkg::CMD_ACK, '0, 64'd5, 63'd1, '0), 1'b1,
                    rp(1'b0, '0, 0, 0, 0, 0)});
    dir.push_back('{mk(pah_pkg::CMD_ACK, '1, '1, '1, '1), 1'b1,
                    rp(1'b1, '0, 1, 1, 0, 0)});
    dir.push_back('{mk(pah_pkg::CMD_ACK, '1, 64'd3, '0, '0), 1'b0, '0});
    dir.push_back('{mk(pah_pkg::CMD_HEART, 32'd5, 64'd99, '0, '0), 1'b0, '0});
    dir.push_back('{mk(pah_pkg::CMD_REG, 32'd5, 64'd40, '0, '0), 1'b0, '0});
    dir.push_back('{mk(pah_pkg::CMD_HORIZON, '0, '0, '0, '1), 1'b0, '0});
    dir.push_back('{mk(pah_pkg::CMD_EJECT, 32'd5, '0, '0, '0), 1'b0, '0});
    dir.push_back('{mk(pah_pkg::CMD_EJECT, 32'd5, '0, '0, '0), 1'b0, '0});
    dir.push_back('{mk(pah_pkg::CMD_EJECT, 32'd9, '0, '0, '0), 1'b0, '0});
    dir.push_back('{mk(pah_pkg::CMD_UNREG, 32'd9, '0, '0, '0), 1'b0, '0});
    dir.push_back('{mk(pah_pkg::CMD_UNREG, 32'd5, '0, '0, '0), 1'b0, '0});
    dir.push_back('{mk(pah_pkg::CMD_UNUSED, 32'd1, '0, '0, '0), 1'b0, '0});
    dir.push_back('{mk(pah_pkg::CMD_HEART, 32'd6, '0, 63'd100, '0), 1'b0, '0});
    dir.push_back('{mk(pah_pkg::CMD_HORIZON, '0, '0, 63'd30100, 64'd8), 1'b0, '0});
    dir.push_back('{mk(pah_pkg::CMD_HORIZON, '0, '0, 63'd30101, 64'd8), 1'b0, '0});
    dir.push_back('{mk(pah_pkg::CMD_HORIZON, '0, '0, 63'd50, 64'd8), 1'b0, '0});
    dir.push_back('{mk(pah_pkg::CMD_RESET, '0, '0, '0, '0), 1'b1,
                    rp(1'b1, '0, 0, 0, 0, 0)});
    // fill the table past full
    for (int i = 1; i <= NPEER + 1; i++)
      dir.push_back('{mk(pah_pkg::CMD_REG, id_t'(i), stamp_t'(i), '0, '0), 1'b0, '0});
    foreach (dir[i]) begin
      if (dir[i].fixed) begin
        drain();
        typed_on = 1'b1;
        typed_r = dir[i].r;
        send_word(dir[i].w);
        typed_on = 1'b0;
      end else begin
        send_word(dir[i].w);
      end
    end
    drain();

    // random phases over several register settings
    for (int ph = 0; ph < 5; ph++) begin
      int n;
      drain();
      case (ph)
        0: begin
          write_reg(pah_pkg::CFG_OWN_ID, 32'd3);
          write_reg(pah_pkg::CFG_LEASE, 32'd1000);
        end
        1: begin
          write_reg(pah_pkg::CFG_OWN_ID, '1);
          write_reg(pah_pkg::CFG_LEASE, 32'd0);
        end
        2: begin
          write_reg(pah_pkg::CFG_OWN_ID, $urandom);
          write_reg(pah_pkg::CFG_LEASE, '1);
        end
        3: begin
          write_reg(pah_pkg::CFG_OWN_ID, 32'd0);
          write_reg(pah_pkg::CFG_LEASE, 32'd300);
        end
        default: begin
          write_reg(pah_pkg::CFG_OWN_ID, 32'd7);
          write_reg(pah_pkg::CFG_LEASE, 32'd2500);
        end
      endcase
      n = 270;
      for (int i = 0; i < n; i++) begin
        // ask the receiver for one long hold-off
        if (ph == 2 && i == 20) hold_req = 1'b1;
        send_word(rand_word((ph == 4) ? 40 : 20));
      end
    end

    drain();
    $display("ran %0d command words, checked %0d replies over 5 register settings",
             words_done, replies_seen);
    if (errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
